[src/paillier_encrypt_decrypt_assert.svh]
// ----------------------------------------------------------------------------
// Paillier engine assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef PAILLIER_ENCRYPT_DECRYPT_ASSERT_SVH
`define PAILLIER_ENCRYPT_DECRYPT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PAILLIER_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PAILLIER_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PAILLIER_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define PAILLIER_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[src/paillier_pkg.sv]
// ----------------------------------------------------------------------------
// Paillier engine package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package paillier_pkg;

   localparam int MOD_BITS_DEF = 16;
   localparam int CFG_W        = 16;
   localparam int IN_W         = 16;
   localparam int CIPH_W       = 32;
   localparam int RES_W        = 32;
   localparam int ST_W         = 2;
   localparam int CSR_IDX_W    = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAMBDA  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MU      = 2'd2;

   // operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // status codes
   localparam logic [ST_W-1:0] ST_OK         = 2'd0;
   localparam logic [ST_W-1:0] ST_BAD_PLAIN  = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD_RANDOM = 2'd2;

   typedef enum logic [2:0] {
      X_PACC, X_BASE, X_ONE, X_T, X_Q
   } x_sel_type;

   typedef enum logic [2:0] {
      Y_BASE, Y_PACC, Y_CIPH, Y_PACCM1, Y_MU
   } y_sel_type;

   typedef enum logic {
      M_NSQ, M_N
   } m_sel_type;

   typedef enum logic [1:0] {
      D_NONE, D_PACC, D_BASE, D_RES
   } dst_type;

   typedef enum logic [1:0] {
      INIT_NONE, INIT_ENC_M, INIT_ENC_R, INIT_DEC
   } init_type;

   typedef struct packed {
      logic      load;
      init_type  init_sel;
      logic      mul_go;
      x_sel_type x_sel;
      y_sel_type y_sel;
      m_sel_type m_sel;
      dst_type   dst;
      logic      shift_exp;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic exp_zero;
      logic exp_lsb;
      logic is_dec;
      logic flag_m;
      logic flag_r;
      logic n_small;
   } sts_type;

endpackage

[src/paillier_mulmod.sv]
// ----------------------------------------------------------------------------
// Paillier modular product unit
// Computes x * y mod m by MSB-first double-and-add, a double step and an add step per bit of y,
// and collects the quotient bits so that x = 1 yields y / m as well.
// ----------------------------------------------------------------------------
module paillier_mulmod
   import paillier_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*MOD_BITS-1:0] op_x,
   input  logic [((2*MOD_BITS > CIPH_W) ? 2*MOD_BITS : CIPH_W)-1:0] op_y,
   input  logic [2*MOD_BITS-1:0] op_m,
   output logic                  done,
   output logic [2*MOD_BITS-1:0] acc,
   output logic [MOD_BITS-1:0]   quot
);

   localparam int SW    = 2 * MOD_BITS;
   localparam int XW    = (SW > CIPH_W) ? SW : CIPH_W;
   localparam int CNT_W = $clog2(XW);

   logic             busy_ff, busy_in;
   logic             ph_ff, ph_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]    acc_ff, acc_in;
   logic [SW-1:0]    x_ff, x_in;
   logic [XW-1:0]    y_ff, y_in;
   logic [MOD_BITS-1:0] q_ff, q_in;
   logic             sub_ff, sub_in;
   logic             done_ff, done_in;
   logic [SW:0]      dbl, sum;
   logic             ge_d, ge_s, last;

   // double and add candidates
   assign dbl  = {acc_ff, 1'b0};
   assign sum  = {1'b0, acc_ff} + {1'b0, x_ff};
   assign ge_d = dbl >= {1'b0, op_m};
   assign ge_s = y_ff[XW-1] && (sum >= {1'b0, op_m});
   assign last = busy_ff && ph_ff && (cnt_ff == CNT_W'(XW - 1));

   // advance one half-step per cycle
   always_comb begin
      busy_in = busy_ff;
      ph_in   = ph_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      q_in    = q_ff;
      sub_in  = sub_ff;
      done_in = last;
      if (start) begin
         busy_in = 1'b1;
         ph_in   = 1'b0;
         cnt_in  = '0;
         acc_in  = '0;
         x_in    = op_x;
         y_in    = op_y;
         q_in    = '0;
         sub_in  = 1'b0;
      end else if (busy_ff) begin
         if (!ph_ff) begin
            acc_in = ge_d ? SW'(dbl - {1'b0, op_m}) : dbl[SW-1:0];
            sub_in = ge_d;
            ph_in  = 1'b1;
         end else begin
            if (y_ff[XW-1]) begin
               acc_in = ge_s ? SW'(sum - {1'b0, op_m}) : sum[SW-1:0];
            end
            q_in   = {q_ff[MOD_BITS-2:0], sub_ff | ge_s};
            y_in   = {y_ff[XW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            ph_in  = 1'b0;
            if (last) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ph_ff   <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ph_ff   <= ph_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      q_ff   <= q_in;
      sub_ff <= sub_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quot = q_ff;

endmodule

[src/paillier_ctrl.sv]
// ----------------------------------------------------------------------------
// Paillier engine controller
// Sequences range checks, the exponentiations and the final products.
// ----------------------------------------------------------------------------
`include "paillier_encrypt_decrypt_assert.svh"

module paillier_ctrl
   import paillier_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CHECK = 9'b000000010,
      S_POW   = 9'b000000100,
      S_PMUL  = 9'b000001000,
      S_PSQR  = 9'b000010000,
      S_RED   = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_FIN   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      PH_ENC_M, PH_ENC_R, PH_DEC
   } phase_type;

   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      cmd.load      = 1'b0;
      cmd.init_sel  = INIT_NONE;
      cmd.mul_go    = 1'b0;
      cmd.x_sel     = X_PACC;
      cmd.y_sel     = Y_BASE;
      cmd.m_sel     = M_NSQ;
      cmd.dst       = D_NONE;
      cmd.shift_exp = 1'b0;
      cmd.out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_dec) begin
               if (sts.n_small) begin
                  state_in = S_DONE;
               end else begin
                  // reduce the ciphertext modulo n squared
                  cmd.mul_go   = 1'b1;
                  cmd.x_sel    = X_ONE;
                  cmd.y_sel    = Y_CIPH;
                  cmd.dst      = D_BASE;
                  cmd.init_sel = INIT_DEC;
                  ph_in        = PH_DEC;
                  state_in     = S_RED;
               end
            end else if (sts.flag_m || sts.flag_r) begin
               state_in = S_DONE;
            end else begin
               cmd.init_sel = INIT_ENC_M;
               ph_in        = PH_ENC_M;
               state_in     = S_POW;
            end
         end
         S_POW: begin
            if (!sts.exp_zero) begin
               cmd.mul_go = 1'b1;
               if (sts.exp_lsb) begin
                  cmd.x_sel = X_PACC;
                  cmd.dst   = D_PACC;
                  state_in  = S_PMUL;
               end else begin
                  cmd.x_sel = X_BASE;
                  cmd.dst   = D_BASE;
                  state_in  = S_PSQR;
               end
            end else begin
               case (ph_ff)
                  PH_ENC_M: begin
                     cmd.init_sel = INIT_ENC_R;
                     ph_in        = PH_ENC_R;
                  end
                  PH_ENC_R: begin
                     cmd.mul_go = 1'b1;
                     cmd.x_sel  = X_T;
                     cmd.y_sel  = Y_PACC;
                     cmd.dst    = D_RES;
                     state_in   = S_FIN;
                  end
                  default: begin
                     // quotient of (u - 1) by n
                     cmd.mul_go = 1'b1;
                     cmd.x_sel  = X_ONE;
                     cmd.y_sel  = Y_PACCM1;
                     cmd.m_sel  = M_N;
                     state_in   = S_DIV;
                  end
               endcase
            end
         end
         S_PMUL: begin
            if (sts.mul_done) begin
               cmd.mul_go = 1'b1;
               cmd.x_sel  = X_BASE;
               cmd.dst    = D_BASE;
               state_in   = S_PSQR;
            end
         end
         S_PSQR: begin
            if (sts.mul_done) begin
               cmd.shift_exp = 1'b1;
               state_in      = S_POW;
            end
         end
         S_RED: begin
            if (sts.mul_done) begin
               state_in = S_POW;
            end
         end
         S_DIV: begin
            if (sts.mul_done) begin
               cmd.mul_go = 1'b1;
               cmd.x_sel  = X_Q;
               cmd.y_sel  = Y_MU;
               cmd.m_sel  = M_N;
               cmd.dst    = D_RES;
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.mul_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_ENC_M;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `PAILLIER_ASSERT_NEXT(a_accept_check, clock, reset, req_valid && !req_stall, state_ff == S_CHECK, "accepted transaction did not start range check")
   `PAILLIER_ASSERT_IMPL(a_done_in_wait, clock, reset, sts.mul_done, state_ff == S_PMUL || state_ff == S_PSQR || state_ff == S_RED || state_ff == S_DIV || state_ff == S_FIN, "product finished outside a wait state")
   `PAILLIER_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid, "loaded result not presented")

endmodule

[src/paillier_dpath.sv]
// ----------------------------------------------------------------------------
// Paillier engine datapath
// Key registers, captured transaction, exponent and accumulator registers,
// the modular product unit and the result register.
// ----------------------------------------------------------------------------
module paillier_dpath
   import paillier_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_operation,
   input  logic [IN_W-1:0]      req_plaintext,
   input  logic [IN_W-1:0]      req_random_factor,
   input  logic [CIPH_W-1:0]    req_cipher_in,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic [RES_W-1:0]     rsp_result_value,
   output logic [ST_W-1:0]      rsp_status
);

   localparam int SW = 2 * MOD_BITS;
   localparam int XW = (SW > CIPH_W) ? SW : CIPH_W;

   logic [MOD_BITS-1:0] mod_ff, lam_key_ff, mu_key_ff;
   logic                op_ff;
   logic [MOD_BITS-1:0] pt_ff, rf_ff, n_ff, lam_ff, mu_ff, exp_ff;
   logic [CIPH_W-1:0]   c_ff;
   logic [SW-1:0]       nsq_ff, pacc_ff, base_ff, t_ff, res_ff;
   m_sel_type           m_sel_ff;
   dst_type             dst_ff;
   logic [RES_W-1:0]    rsp_value_ff;
   logic [ST_W-1:0]     rsp_status_ff, status_in;
   logic [SW-1:0]       op_x, op_m, mm_acc;
   logic [XW-1:0]       op_y;
   logic [MOD_BITS-1:0] mm_quot;
   logic                mm_done;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff     <= MOD_BITS'(143);
         lam_key_ff <= MOD_BITS'(60);
         mu_key_ff  <= MOD_BITS'(31);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: mod_ff     <= MOD_BITS'(csr_data);
            CSR_LAMBDA:  lam_key_ff <= MOD_BITS'(csr_data);
            CSR_MU:      mu_key_ff  <= MOD_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   // operand selection for the product unit
   always_comb begin
      case (cmd.x_sel)
         X_PACC:  op_x = pacc_ff;
         X_BASE:  op_x = base_ff;
         X_ONE:   op_x = SW'(1);
         X_T:     op_x = t_ff;
         X_Q:     op_x = SW'(mm_quot);
         default: op_x = '0;
      endcase
      case (cmd.y_sel)
         Y_BASE:   op_y = XW'(base_ff);
         Y_PACC:   op_y = XW'(pacc_ff);
         Y_CIPH:   op_y = XW'(c_ff);
         Y_PACCM1: op_y = (pacc_ff == '0) ? '0 : XW'(pacc_ff - SW'(1));
         Y_MU:     op_y = XW'(mu_ff);
         default:  op_y = '0;
      endcase
      op_m = (m_sel_ff == M_NSQ) ? nsq_ff : SW'(n_ff);
   end

   paillier_mulmod #(
      .MOD_BITS (MOD_BITS)
   ) u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_go),
      .op_x  (op_x),
      .op_y  (op_y),
      .op_m  (op_m),
      .done  (mm_done),
      .acc   (mm_acc),
      .quot  (mm_quot)
   );

   // capture, exponent and accumulator registers
   always_ff @(posedge clock) begin
      nsq_ff <= SW'(n_ff) * SW'(n_ff);
      if (cmd.load) begin
         op_ff  <= req_operation;
         pt_ff  <= MOD_BITS'(req_plaintext);
         rf_ff  <= MOD_BITS'(req_random_factor);
         c_ff   <= req_cipher_in;
         n_ff   <= mod_ff;
         lam_ff <= lam_key_ff;
         mu_ff  <= mu_key_ff;
         res_ff <= '0;
      end
      case (cmd.init_sel)
         INIT_ENC_M: begin
            pacc_ff <= SW'(1);
            base_ff <= SW'(n_ff) + SW'(1);
            exp_ff  <= pt_ff;
         end
         INIT_ENC_R: begin
            t_ff    <= pacc_ff;
            pacc_ff <= SW'(1);
            base_ff <= SW'(rf_ff);
            exp_ff  <= n_ff;
         end
         INIT_DEC: begin
            pacc_ff <= SW'(1);
            exp_ff  <= lam_ff;
         end
         default: begin
         end
      endcase
      if (cmd.shift_exp) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.mul_go) begin
         m_sel_ff <= cmd.m_sel;
         dst_ff   <= cmd.dst;
      end
      // write back a finished product
      if (mm_done) begin
         case (dst_ff)
            D_PACC:  pacc_ff <= mm_acc;
            D_BASE:  base_ff <= mm_acc;
            D_RES:   res_ff  <= mm_acc;
            default: begin
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_value_ff  <= RES_W'(res_ff);
         rsp_status_ff <= status_in;
      end
   end

   // flags and status code
   always_comb begin
      sts.mul_done = mm_done;
      sts.exp_zero = (exp_ff == '0);
      sts.exp_lsb  = exp_ff[0];
      sts.is_dec   = (op_ff == OP_DECRYPT);
      sts.flag_m   = (pt_ff >= n_ff);
      sts.flag_r   = (rf_ff == '0) || (rf_ff >= n_ff);
      sts.n_small  = (n_ff[MOD_BITS-1:1] == '0);
      if (sts.is_dec) begin
         status_in = ST_OK;
      end else if (sts.flag_m) begin
         status_in = ST_BAD_PLAIN;
      end else if (sts.flag_r) begin
         status_in = ST_BAD_RANDOM;
      end else begin
         status_in = ST_OK;
      end
   end

   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[src/paillier_encrypt_decrypt.sv]
// A checked-out or degenerate transaction runs no products and only waits for the output.
// Each modular product runs in the shared product unit.
// Encrypt runs about 2*(bits(m)+bits(n))+1 products, decrypt 2*bits(lambda)+3 products.
// One transaction is worked at a time.
// Synchronous reset clears control state and loads keys n = 143, lambda = 60, mu = 31.
// ----------------------------------------------------------------------------
// Paillier encrypt/decrypt engine
// Top level: key port, request/response channels, controller and datapath.
// ----------------------------------------------------------------------------
module paillier_encrypt_decrypt
   import paillier_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [IN_W-1:0]      req_plaintext,
   input  logic [IN_W-1:0]      req_random_factor,
   input  logic [CIPH_W-1:0]    req_cipher_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RES_W-1:0]     rsp_result_value,
   output logic [ST_W-1:0]      rsp_status
);

   cmd_type cmd;
   sts_type sts;

   // key writes are always taken
   assign csr_ready = 1'b1;

   paillier_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   paillier_dpath #(
      .MOD_BITS (MOD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_operation     (req_operation),
      .req_plaintext     (req_plaintext),
      .req_random_factor (req_random_factor),
      .req_cipher_in     (req_cipher_in),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Paillier engine testbench
// Drives encrypt and decrypt transactions under several key settings,
// predicts every response in SystemVerilog and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
   import paillier_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic              op;
      logic [IN_W-1:0]   plain;
      logic [IN_W-1:0]   blind;
      logic [CIPH_W-1:0] cipher;
   } cipher_req_t;

   typedef struct {
      logic [RES_W-1:0] value;
      logic [ST_W-1:0]  status;
   } cipher_rsp_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_operation = OP_ENCRYPT;
   logic [IN_W-1:0]      req_plaintext = '0;
   logic [IN_W-1:0]      req_random_factor = '0;
   logic [CIPH_W-1:0]    req_cipher_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [RES_W-1:0]     rsp_result_value;
   logic [ST_W-1:0]      rsp_status;

   // key copy held by the predictor
   longint unsigned key_n, key_lambda, key_mu;

   cipher_rsp_t     pending_rsp[$];
   longint unsigned last_cipher;
   int              mismatches = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;
   int              stall_phase = 0;
   int              stall_mode = 0;

   paillier_encrypt_decrypt DUT (.*);

   always #10 clock = ~clock;

   // ------------------------------------------------------------------ model
   function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
      return ((a % m) * (b % m)) % m;
   endfunction

   function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                               longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      base = base % m;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base, m);
         base = mod_mul(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic cipher_rsp_t predict_cipher(cipher_req_t t);
      cipher_rsp_t     p;
      longint unsigned nsq, u, l;
      nsq = key_n * key_n;
      p.value = '0;
      p.status = ST_OK;
      if (t.op == OP_ENCRYPT) begin
         if (t.plain >= key_n) begin
            p.status = ST_BAD_PLAIN;
         end else if (t.blind == 0 || t.blind >= key_n) begin
            p.status = ST_BAD_RANDOM;
         end else begin
            p.value = mod_mul(mod_pow(key_n + 1, t.plain, nsq),
                              mod_pow(t.blind, key_n, nsq), nsq);
         end
      end else if (key_n != 0) begin
         u = mod_pow(t.cipher, key_lambda, nsq);
         l = (u == 0) ? 0 : (u - 1) / key_n;
         p.value = mod_mul(l, key_mu, key_n);
      end
      return p;
   endfunction

   // ------------------------------------------------------------- drivers
   task automatic write_key(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODULUS: key_n = val;
         CSR_LAMBDA:  key_lambda = val;
         CSR_MU:      key_mu = val;
         default: ;
      endcase
   endtask

   // drop the request, wait for all responses, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_keys(longint unsigned n, longint unsigned lam, longint unsigned mu);
      drain();
      write_key(CSR_MODULUS, n);
      write_key(CSR_LAMBDA, lam);
      write_key(CSR_MU, mu);
   endtask

   task automatic send_cipher(cipher_req_t t);
      cipher_rsp_t p;
      // insert a gap between most bursts
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_operation     <= t.op;
      req_plaintext     <= t.plain;
      req_random_factor <= t.blind;
      req_cipher_in     <= t.cipher;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_cipher(t);
      if (t.op == OP_ENCRYPT && p.status == ST_OK) last_cipher = p.value;
      pending_rsp.push_back(p);
   endtask

   task automatic send_enc(longint unsigned m, longint unsigned r);
      cipher_req_t t;
      t.op = OP_ENCRYPT;
      t.plain = m;
      t.blind = r;
      t.cipher = $urandom();
      send_cipher(t);
   endtask

   task automatic send_dec(longint unsigned c);
      cipher_req_t t;
      t.op = OP_DECRYPT;
      t.plain = $urandom();
      t.blind = $urandom();
      t.cipher = c;
      send_cipher(t);
   endtask

   // ---------------------------------------------------------------- keys
   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic longint unsigned inverse_of(longint unsigned a, longint unsigned m);
      longint r0, r1, s0, s1, q, t;
      r0 = m;
      r1 = a % m;
      s0 = 0;
      s1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         t = r0 - q * r1; r0 = r1; r1 = t;
         t = s0 - q * s1; s0 = s1; s1 = t;
      end
      if (s0 < 0) s0 += m;
      return s0;
   endfunction

   // pick a valid key set from two distinct small primes
   task automatic load_random_keys();
      int              primes[] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                                    53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 251};
      longint unsigned p, q, n, lam;
      do begin
         p = primes[$urandom_range(0, primes.size() - 1)];
         q = primes[$urandom_range(0, primes.size() - 1)];
         n = p * q;
         lam = (p - 1) * (q - 1) / gcd_of(p - 1, q - 1);
      end while (p == q || gcd_of(lam, n) != 1);
      load_keys(n, lam, inverse_of(lam, n));
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_keys();
      send_enc(0, 1);
      send_enc(142, 142);
      send_enc(42, 17);
      send_dec(last_cipher);
      send_enc(143, 5);
      send_enc(65535, 0);
      send_enc(5, 0);
      send_enc(5, 143);
      send_enc(5, 65535);
      send_dec(0);
      send_dec(1);
      send_dec(32'hFFFF_FFFF);
      send_dec(143 * 143);
   endtask

   task automatic test_key_extremes();
      load_keys(65535, 65535, 65535);
      send_enc(65534, 65534);
      send_dec(32'hFFFF_FFFF);
      load_keys(0, 0, 0);
      send_enc(0, 1);
      send_dec(12345);
      load_keys(1, 1, 1);
      send_enc(0, 0);
      send_enc(1, 0);
      send_dec(7);
      load_keys(2, 1, 1);
      send_enc(1, 1);
      send_dec(3);
      load_keys(35, 0, 40);
      send_dec(9);
   endtask

   task automatic test_random_traffic(int count, bit raw_keys);
      longint unsigned pick, nsq;
      if (raw_keys)
         load_keys($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
         load_random_keys();
      nsq = key_n * key_n;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 19);
         if (key_n < 2 || pick < 2)
            send_enc($urandom_range(0, 65535), $urandom_range(0, 65535));
         else if (pick < 4)
            send_enc($urandom_range(0, key_n - 1), (pick == 2) ? 0 : $urandom_range(key_n, 65535));
         else if (pick < 10)
            send_enc($urandom_range(0, key_n - 1), $urandom_range(1, key_n - 1));
         else if (pick < 15)
            send_dec(last_cipher);
         else if (pick < 18 && nsq != 0)
            send_dec($urandom() % nsq);
         else
            send_dec($urandom());
      end
   endtask

   // -------------------------------------------------------------- checker
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cipher_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_result_value, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_result_value !== want.value)
               report_mismatch("result_value", rsp_result_value, want.value);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // receiver backpressure: switch at random between quiet, light and heavy stall stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_phase = $urandom_range(1, 200);
            stall_mode = $urandom_range(0, 2);
         end
         stall_phase--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // abort when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------- sequence
   initial begin
      key_n = 143;
      key_lambda = 60;
      key_mu = 31;
      last_cipher = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_keys();
      test_key_extremes();
      for (int k = 0; k < 4; k++) test_random_traffic(25, 1'b0);
      test_random_traffic(15, 1'b1);
      test_random_traffic(10, 1'b1);
      req_valid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
